// ===== design/lsrs_pkg.sv =====
`timescale 1ns / 1ps
package lsrs_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int INDEX_DEPTH = 1024;
    localparam int SYMBOL_BITS = 16;

    localparam int OP_W     = 2;
    localparam int SYM_W    = 16;
    localparam int ADDR_W   = 14;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int ST_AW  = $clog2(STORE_DEPTH);
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int IX_AW  = $clog2(INDEX_DEPTH);
    localparam int IXF_W  = $clog2(INDEX_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_APPEND   = 2'd0;
    localparam logic [OP_W-1:0] OP_RD_INDEX = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_STORE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_COMMIT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROP   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd3;

endpackage

// ===== design/lsrs_if.sv =====
`timescale 1ns / 1ps
interface lsrs_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsrs_pkg::OP_W-1:0]   op;
    logic [lsrs_pkg::SYM_W-1:0]  symbol;
    logic                        last;
    logic [lsrs_pkg::ADDR_W-1:0] address;

    modport source (output valid, output op, output symbol, output last, output address,
                    input ready);
    modport sink   (input valid, input op, input symbol, input last, input address,
                    output ready);
endinterface

interface lsrs_out_if;
    logic                          valid;
    logic                          ready;
    logic [lsrs_pkg::DATA_W-1:0]   data;
    logic [lsrs_pkg::STATUS_W-1:0] status;
    logic [lsrs_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input data, input status, input entry_count,
                    output ready);
endinterface

// ===== design/lsrs_ram.sv =====
`timescale 1ns / 1ps
module lsrs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/length_sorted_record_store.sv =====
`timescale 1ns / 1ps
// Record store with a length-sorted index. Every item returns one result. A commit (append
// with last) writes the length word and then walks the index down from its top: each index
// entry whose record is longer than the new one moves one slot up, and each such entry costs
// an index read, a store read of its length word and a write one slot up, all through the
// one read and one write port of each memory and one length comparator.
// The input is not ready while an item is in work; it is ready again while a finished result
// still waits in the output register. The stores need no clearing after reset.
module length_sorted_record_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsrs_in_if.sink     i_in,
    lsrs_out_if.source  o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RWAIT = 4'd2;
    localparam logic [3:0] S_LENW  = 4'd3;
    localparam logic [3:0] S_WCHK  = 4'd4;
    localparam logic [3:0] S_WIDX  = 4'd5;
    localparam logic [3:0] S_WLEN  = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int ST_AW  = lsrs_pkg::ST_AW;
    localparam int FILL_W = lsrs_pkg::FILL_W;
    localparam int IX_AW  = lsrs_pkg::IX_AW;
    localparam int IXF_W  = lsrs_pkg::IXF_W;
    localparam int DATA_W = lsrs_pkg::DATA_W;
    localparam int STW    = lsrs_pkg::SYMBOL_BITS;

    logic [3:0]                      r_state, n_state;
    logic [lsrs_pkg::OP_W-1:0]       r_op;
    logic [lsrs_pkg::SYM_W-1:0]      r_symbol;
    logic                            r_last;
    logic [lsrs_pkg::ADDR_W-1:0]     r_addr;
    logic [FILL_W-1:0]               r_store_fill, n_store_fill;
    logic [IXF_W-1:0]                r_index_fill, n_index_fill;
    logic [ST_AW-1:0]                r_record_start, n_record_start;
    logic [FILL_W-1:0]               r_tally, n_tally;
    logic                            r_open, n_open;
    logic                            r_ovf, n_ovf;
    logic [IX_AW-1:0]                r_k, n_k;
    logic [ST_AW-1:0]                r_off, n_off;
    logic [DATA_W-1:0]               r_len, n_len;
    logic                            r_rd_zero, n_rd_zero;
    logic [DATA_W-1:0]               r_res_data, n_res_data;
    logic [lsrs_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic                            r_out_valid, n_out_valid;
    logic [DATA_W-1:0]               r_out_data, n_out_data;
    logic [lsrs_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [lsrs_pkg::COUNT_W-1:0]    r_out_count, n_out_count;

    logic             st_we, st_re;
    logic [ST_AW-1:0] st_waddr, st_raddr;
    logic [STW-1:0]   st_wdata, st_rdata;
    logic             ix_we, ix_re;
    logic [IX_AW-1:0] ix_waddr, ix_raddr;
    logic [ST_AW-1:0] ix_wdata, ix_rdata;

    logic [FILL_W-1:0] a_fill;
    logic [ST_AW-1:0]  a_start;
    logic [FILL_W-1:0] a_tally;
    logic              a_ovf;
    logic              len_less;

    lsrs_ram #(.DEPTH(lsrs_pkg::STORE_DEPTH), .WIDTH(STW)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    lsrs_ram #(.DEPTH(lsrs_pkg::INDEX_DEPTH), .WIDTH(ST_AW)) u_index (
        .i_clk   (i_clk),
        .i_we    (ix_we),
        .i_waddr (ix_waddr),
        .i_wdata (ix_wdata),
        .i_re    (ix_re),
        .i_raddr (ix_raddr),
        .o_rdata (ix_rdata)
    );

    assign len_less = r_len < DATA_W'(st_rdata);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.data        = r_out_data;
    assign o_out.status      = r_out_status;
    assign o_out.entry_count = r_out_count;

    always_comb begin
        n_state        = r_state;
        n_store_fill   = r_store_fill;
        n_index_fill   = r_index_fill;
        n_record_start = r_record_start;
        n_tally        = r_tally;
        n_open         = r_open;
        n_ovf          = r_ovf;
        n_k            = r_k;
        n_off          = r_off;
        n_len          = r_len;
        n_rd_zero      = r_rd_zero;
        n_res_data     = r_res_data;
        n_res_status   = r_res_status;
        n_out_valid    = r_out_valid & ~o_out.ready;
        n_out_data     = r_out_data;
        n_out_status   = r_out_status;
        n_out_count    = r_out_count;

        st_we    = 1'b0;
        st_waddr = r_store_fill[ST_AW-1:0];
        st_wdata = STW'(r_symbol);
        st_re    = 1'b0;
        st_raddr = r_addr[ST_AW-1:0];
        ix_we    = 1'b0;
        ix_waddr = r_k;
        ix_wdata = r_record_start;
        ix_re    = 1'b0;
        ix_raddr = r_addr[IX_AW-1:0];

        a_fill  = r_store_fill;
        a_start = r_record_start;
        a_tally = r_tally;
        a_ovf   = r_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_data   = '0;
                n_res_status = lsrs_pkg::STAT_OK;
                n_state      = S_DONE;
                unique case (r_op)
                    lsrs_pkg::OP_APPEND: begin
                        if (!r_open) begin
                            a_start = r_store_fill[ST_AW-1:0];
                            a_tally = '0;
                            a_ovf   = 1'b0;
                            if (r_store_fill >= FILL_W'(lsrs_pkg::STORE_DEPTH - 1)) begin
                                a_ovf = 1'b1;
                            end else begin
                                a_fill = r_store_fill + FILL_W'(1);
                            end
                        end
                        if (!a_ovf) begin
                            if (a_fill >= FILL_W'(lsrs_pkg::STORE_DEPTH)) begin
                                a_fill = FILL_W'(a_start);
                                a_ovf  = 1'b1;
                            end else begin
                                st_we    = 1'b1;
                                st_waddr = a_fill[ST_AW-1:0];
                                a_fill   = a_fill + FILL_W'(1);
                                a_tally  = a_tally + FILL_W'(1);
                            end
                        end
                        n_store_fill   = a_fill;
                        n_record_start = a_start;
                        n_tally        = a_tally;
                        n_open         = 1'b1;
                        n_ovf          = a_ovf;
                        if (a_ovf) begin
                            n_res_status = lsrs_pkg::STAT_DROP;
                            if (r_last) begin
                                n_open  = 1'b0;
                                n_ovf   = 1'b0;
                                n_tally = '0;
                            end
                        end else if (r_last) begin
                            if (r_index_fill >= IXF_W'(lsrs_pkg::INDEX_DEPTH)) begin
                                n_store_fill = FILL_W'(a_start);
                                n_open       = 1'b0;
                                n_ovf        = 1'b0;
                                n_tally      = '0;
                                n_res_status = lsrs_pkg::STAT_DROP;
                            end else begin
                                n_len   = DATA_W'(a_tally - FILL_W'(1));
                                n_state = S_LENW;
                            end
                        end
                    end
                    lsrs_pkg::OP_RD_INDEX: begin
                        if (IXF_W'(r_addr) < r_index_fill
                            && r_addr < lsrs_pkg::ADDR_W'(lsrs_pkg::INDEX_DEPTH)) begin
                            ix_re     = 1'b1;
                            n_rd_zero = 1'b0;
                            n_state   = S_RWAIT;
                        end else begin
                            n_res_status = lsrs_pkg::STAT_RANGE;
                        end
                    end
                    lsrs_pkg::OP_RD_STORE: begin
                        if (FILL_W'(r_addr) < r_store_fill) begin
                            st_re     = 1'b1;
                            n_rd_zero = r_open && !r_ovf
                                        && (r_addr[ST_AW-1:0] == r_record_start);
                            n_state   = S_RWAIT;
                        end else begin
                            n_res_status = lsrs_pkg::STAT_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RWAIT: begin
                if (r_rd_zero) begin
                    n_res_data = '0;
                end else if (r_op == lsrs_pkg::OP_RD_INDEX) begin
                    n_res_data = DATA_W'(ix_rdata);
                end else begin
                    n_res_data = DATA_W'(st_rdata);
                end
                n_state = S_DONE;
            end
            S_LENW: begin
                st_we    = 1'b1;
                st_waddr = r_record_start;
                st_wdata = STW'(r_len);
                n_k      = r_index_fill[IX_AW-1:0];
                n_state  = S_WCHK;
            end
            S_WCHK: begin
                if (r_k == '0) begin
                    n_state = S_INS;
                end else begin
                    ix_re    = 1'b1;
                    ix_raddr = r_k - IX_AW'(1);
                    n_state  = S_WIDX;
                end
            end
            S_WIDX: begin
                n_off    = ix_rdata;
                st_re    = 1'b1;
                st_raddr = ix_rdata;
                n_state  = S_WLEN;
            end
            S_WLEN: begin
                if (len_less) begin
                    ix_we    = 1'b1;
                    ix_wdata = r_off;
                    n_k      = r_k - IX_AW'(1);
                    n_state  = S_WCHK;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                ix_we        = 1'b1;
                n_index_fill = r_index_fill + IXF_W'(1);
                n_open       = 1'b0;
                n_ovf        = 1'b0;
                n_tally      = '0;
                n_res_status = lsrs_pkg::STAT_COMMIT;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_out_count  = lsrs_pkg::COUNT_W'(r_index_fill);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_store_fill   <= '0;
            r_index_fill   <= '0;
            r_record_start <= '0;
            r_tally        <= '0;
            r_open         <= 1'b0;
            r_ovf          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_store_fill   <= n_store_fill;
            r_index_fill   <= n_index_fill;
            r_record_start <= n_record_start;
            r_tally        <= n_tally;
            r_open         <= n_open;
            r_ovf          <= n_ovf;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op     <= i_in.op;
            r_symbol <= i_in.symbol;
            r_last   <= i_in.last;
            r_addr   <= i_in.address;
        end
        r_k          <= n_k;
        r_off        <= n_off;
        r_len        <= n_len;
        r_rd_zero    <= n_rd_zero;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

endmodule

// ===== tb/sv/tb_length_sorted_record_store.sv =====
`timescale 1ns / 1ps
module tb_length_sorted_record_store;

    localparam logic [lsrs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 240;
    localparam int MAX_REC_SYMBOLS = 8;

    typedef struct packed {
        logic [lsrs_pkg::DATA_W-1:0]   data;
        logic [lsrs_pkg::STATUS_W-1:0] status;
        logic [lsrs_pkg::COUNT_W-1:0]  count;
    } t_store_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsrs_in_if  in_ch();
    lsrs_out_if out_ch();

    length_sorted_record_store uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    logic [lsrs_pkg::DATA_W-1:0] store_words [lsrs_pkg::STORE_DEPTH];
    logic [lsrs_pkg::ST_AW-1:0]  index_slots [lsrs_pkg::INDEX_DEPTH];
    logic [lsrs_pkg::FILL_W-1:0] store_level;
    logic [lsrs_pkg::IXF_W-1:0]  index_level;
    logic [lsrs_pkg::ST_AW-1:0]  open_start;
    logic [lsrs_pkg::FILL_W-1:0] open_count;
    logic                        rec_open;
    logic                        rec_dropped;

    t_store_reply replies_due[$];
    int bad_replies    = 0;
    int reply_number   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stimulus_items = 0;

    function automatic t_store_reply predict_reply(input logic [lsrs_pkg::OP_W-1:0] op,
                                                   input logic [lsrs_pkg::SYM_W-1:0] sym,
                                                   input logic lst,
                                                   input logic [lsrs_pkg::ADDR_W-1:0] addr);
        t_store_reply r;
        logic [lsrs_pkg::DATA_W-1:0] len;
        int slot;
        r.data = '0;
        r.status = lsrs_pkg::STAT_OK;
        if (op == lsrs_pkg::OP_APPEND) begin
            if (!rec_open) begin
                rec_open = 1'b1;
                rec_dropped = 1'b0;
                open_count = '0;
                open_start = lsrs_pkg::ST_AW'(store_level);
                if (store_level + 2 > lsrs_pkg::STORE_DEPTH) begin
                    rec_dropped = 1'b1;
                end else begin
                    store_words[store_level] = '0;
                    store_level++;
                end
            end
            if (!rec_dropped) begin
                if (store_level + 1 > lsrs_pkg::STORE_DEPTH) begin
                    store_level = open_start;
                    rec_dropped = 1'b1;
                end else begin
                    store_words[store_level] = sym;
                    store_level++;
                    open_count++;
                end
            end
            if (rec_dropped) begin
                r.status = lsrs_pkg::STAT_DROP;
                if (lst) begin
                    rec_open = 1'b0;
                    rec_dropped = 1'b0;
                    open_count = '0;
                end
            end else if (lst) begin
                if (index_level >= lsrs_pkg::INDEX_DEPTH) begin
                    store_level = open_start;
                    r.status = lsrs_pkg::STAT_DROP;
                end else begin
                    len = lsrs_pkg::DATA_W'(open_count - 1'b1);
                    store_words[open_start] = len;
                    slot = index_level;
                    while (slot > 0 && len < store_words[index_slots[slot-1]])
                        slot--;
                    for (int k = index_level; k > slot; k--)
                        index_slots[k] = index_slots[k-1];
                    index_slots[slot] = open_start;
                    index_level++;
                    r.status = lsrs_pkg::STAT_COMMIT;
                end
                rec_open = 1'b0;
                rec_dropped = 1'b0;
                open_count = '0;
            end
        end else if (op == lsrs_pkg::OP_RD_INDEX) begin
            if (addr < index_level)
                r.data = lsrs_pkg::DATA_W'(index_slots[addr]);
            else
                r.status = lsrs_pkg::STAT_RANGE;
        end else if (op == lsrs_pkg::OP_RD_STORE) begin
            if (addr < store_level)
                r.data = store_words[addr];
            else
                r.status = lsrs_pkg::STAT_RANGE;
        end
        r.count = lsrs_pkg::COUNT_W'(index_level);
        return r;
    endfunction

    task automatic send_item(input logic [lsrs_pkg::OP_W-1:0] op,
                             input logic [lsrs_pkg::SYM_W-1:0] sym,
                             input logic lst, input logic [lsrs_pkg::ADDR_W-1:0] addr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.symbol  <= sym;
        in_ch.last    <= lst;
        in_ch.address <= addr;
        do @(posedge i_clk); while (!in_ch.ready);
        replies_due.push_back(predict_reply(op, sym, lst, addr));
        if (op != OP_UNUSED)
            stimulus_items++;
    endtask

    task automatic await_replies();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    task automatic send_read();
        logic [lsrs_pkg::OP_W-1:0] op;
        logic [lsrs_pkg::ADDR_W-1:0] addr;
        int lim;
        int pick;
        op = $urandom_range(1) ? lsrs_pkg::OP_RD_STORE : lsrs_pkg::OP_RD_INDEX;
        lim = (op == lsrs_pkg::OP_RD_INDEX) ? int'(index_level) : int'(store_level);
        pick = $urandom_range(9);
        if (pick < 7 && lim > 0)
            addr = lsrs_pkg::ADDR_W'($urandom_range(lim - 1));
        else if (pick < 8)
            addr = lsrs_pkg::ADDR_W'(lim);
        else
            addr = lsrs_pkg::ADDR_W'($urandom);
        send_item(op, lsrs_pkg::SYM_W'($urandom), 1'($urandom), addr);
    endtask

    task automatic send_record(input int symbols, input int mix_pct);
        int i;
        for (i = 0; i < symbols; i++) begin
            send_item(lsrs_pkg::OP_APPEND, lsrs_pkg::SYM_W'($urandom), i == symbols - 1,
                      lsrs_pkg::ADDR_W'($urandom));
            if (i < symbols - 1 && $urandom_range(99) < mix_pct) begin
                if ($urandom_range(3) == 0)
                    send_item(OP_UNUSED, lsrs_pkg::SYM_W'($urandom), 1'($urandom),
                              lsrs_pkg::ADDR_W'($urandom));
                else
                    send_read();
            end
        end
    endtask

    task automatic test_directed();
        int s;
        send_item(lsrs_pkg::OP_RD_INDEX, 16'hFFFF, 1'b1, 14'h0000);
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, 14'h3FFF);
        send_item(OP_UNUSED,             16'hFFFF, 1'b1, 14'h3FFF);
        send_item(lsrs_pkg::OP_APPEND,   16'hFFFF, 1'b0, 14'h3FFF);
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, 14'd0);
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, 14'd1);
        send_item(lsrs_pkg::OP_RD_INDEX, 16'h0000, 1'b0, 14'd0);
        send_item(lsrs_pkg::OP_APPEND,   16'h0000, 1'b1, 14'h0000);
        send_item(lsrs_pkg::OP_APPEND,   16'h1234, 1'b1, 14'h1555);
        send_item(lsrs_pkg::OP_APPEND,   16'h00AA, 1'b0, 14'h2AAA);
        send_item(lsrs_pkg::OP_APPEND,   16'h00BB, 1'b0, 14'h0000);
        send_item(lsrs_pkg::OP_APPEND,   16'h00CC, 1'b1, 14'h0000);
        send_item(lsrs_pkg::OP_APPEND,   16'h5555, 1'b1, 14'h0000);
        for (s = 0; s <= 4; s++)
            send_item(lsrs_pkg::OP_RD_INDEX, 16'h0000, 1'b0, lsrs_pkg::ADDR_W'(s));
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, 14'd9);
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, 14'd10);
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, 14'd11);
        send_item(OP_UNUSED,             16'h0000, 1'b0, 14'h0000);
    endtask

    task automatic test_random();
        int send_mix[4]  = '{0, 49, 0, 13};
        int stall_mix[4] = '{0, 0, 49, 13};
        int phase;
        int start;
        int pick;
        for (phase = 0; phase < 4; phase++) begin
            await_replies();
            send_idle_pct  = send_mix[phase];
            recv_stall_pct = stall_mix[phase];
            start = stimulus_items;
            while (stimulus_items - start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    send_record($urandom_range(MAX_REC_SYMBOLS, 1), 15);
                else if (pick < 92)
                    send_read();
                else
                    send_item(OP_UNUSED, lsrs_pkg::SYM_W'($urandom), 1'($urandom),
                              lsrs_pkg::ADDR_W'($urandom));
            end
        end
    endtask

    // Single-symbol fillers are the shortest, so each commit moves every longer entry up.
    task automatic test_index_full();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (index_level < lsrs_pkg::INDEX_DEPTH)
            send_record(1, 0);
        send_item(lsrs_pkg::OP_RD_INDEX, 16'h0000, 1'b0,
                  lsrs_pkg::ADDR_W'(lsrs_pkg::INDEX_DEPTH - 1));
        send_item(lsrs_pkg::OP_RD_INDEX, 16'h0000, 1'b0,
                  lsrs_pkg::ADDR_W'(lsrs_pkg::INDEX_DEPTH));
        send_record(1, 0);
        send_record(3, 0);
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, lsrs_pkg::ADDR_W'(store_level));
        send_item(lsrs_pkg::OP_RD_STORE, 16'h0000, 1'b0, lsrs_pkg::ADDR_W'(store_level - 1));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            reply_number++;
            if (replies_due.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("reply %0d unexpected: data %h status %0d count %0d",
                             reply_number, out_ch.data, out_ch.status, out_ch.entry_count);
            end else begin
                t_store_reply want;
                want = replies_due.pop_front();
                if (out_ch.data !== want.data || out_ch.status !== want.status ||
                    out_ch.entry_count !== want.count) begin
                    bad_replies++;
                    if (bad_replies <= 10)
                        $display({"reply %0d: expected data %h status %0d count %0d, ",
                                  "got data %h status %0d count %0d"},
                                 reply_number, want.data, want.status, want.count,
                                 out_ch.data, out_ch.status, out_ch.entry_count);
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.op      = lsrs_pkg::OP_APPEND;
        in_ch.symbol  = '0;
        in_ch.last    = 1'b0;
        in_ch.address = '0;
        store_level   = '0;
        index_level   = '0;
        open_start    = '0;
        open_count    = '0;
        rec_open      = 1'b0;
        rec_dropped   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_index_full();
        await_replies();
        repeat (20) @(posedge i_clk);
        if (bad_replies == 0 && replies_due.size() == 0) begin
            $display("tb_length_sorted_record_store passed");
        end else begin
            $display("tb_length_sorted_record_store failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_length_sorted_record_store failed");
        $finish;
    end

endmodule
